FILE: rtl/ihbf_pkg.sv
// Shared types and constants for the IPv4 header build and fragment unit.
// No dependencies; every other file imports this package.
`default_nettype none

package ihbf_pkg;

   localparam int HDR_BYTES = 20;
   localparam int IDX_W     = $clog2(HDR_BYTES + 1);

   localparam logic [IDX_W-1:0] PAYLOAD_INDEX = IDX_W'(HDR_BYTES);

   localparam logic [7:0]  VERSION_IHL = 8'h45;
   localparam logic [7:0]  TTL_VALUE   = 8'd64;
   localparam logic [15:0] FLAG_MF     = 16'h2000;
   localparam logic [15:0] FLAG_DF     = 16'h4000;
   localparam logic [13:0] MTU_MIN     = 14'd68;
   localparam logic [13:0] MTU_MAX     = 14'd9000;
   localparam logic [13:0] MTU_RESET   = 14'd1500;
   localparam logic [15:0] HDR_LEN16   = 16'd20;

   typedef enum logic [1:0] {
      CSR_MTU = 2'd0,
      CSR_SRC = 2'd1,
      CSR_DST = 2'd2,
      CSR_ID  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [15:0] segment_length;
      logic [7:0]  upper_protocol;
      logic        dont_fragment;
      logic        last_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_datagram;
      logic       end_of_segment;
      logic       status;
   } rsp_word_type;

   typedef struct packed {
      logic [13:0] mtu;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] identification;
   } cfg_type;

   // one accepted byte's worth of results: optional header, then one byte
   typedef struct packed {
      logic        has_header;
      logic [15:0] total_length;
      logic [15:0] flags_offset;
      logic [7:0]  protocol;
      logic [7:0]  data_byte;
      logic        eod;
      logic        eos;
      logic        status;
   } plan_type;

endpackage

`default_nettype wire

FILE: rtl/ihbf_csr.sv
// Configuration registers: MTU, addresses and identification.
// Depends on ihbf_pkg.
`default_nettype none

module ihbf_csr (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_write_enable,
   input  ihbf_pkg::csr_index_type   csr_index,
   input  wire [31:0]                csr_write_data,
   output ihbf_pkg::cfg_type         cfg
);
   import ihbf_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mtu                 <= MTU_RESET;
         cfg_ff.source_address      <= '0;
         cfg_ff.destination_address <= '0;
         cfg_ff.identification      <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MTU: cfg_ff.mtu                 <= csr_write_data[13:0];
            CSR_SRC: cfg_ff.source_address      <= csr_write_data;
            CSR_DST: cfg_ff.destination_address <= csr_write_data;
            CSR_ID:  cfg_ff.identification      <= csr_write_data[15:0];
            default: cfg_ff.mtu                 <= cfg_ff.mtu;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/ihbf_seg_ctrl.sv
// Segment tracking: latches segment attributes, sizes fragments and
// registers at most one plan per input word. Depends on ihbf_pkg.
`default_nettype none

module ihbf_seg_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  ihbf_pkg::cfg_type      cfg,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  ihbf_pkg::req_word_type req_word,
   output logic                   plan_valid,
   input  wire                    plan_ready,
   output ihbf_pkg::plan_type     plan
);
   import ihbf_pkg::*;

   logic [15:0] len_ff, len_in;
   logic [7:0]  proto_ff, proto_in;
   logic        df_ff, df_in;
   logic [15:0] seg_pos_ff, seg_pos_in;
   logic [13:0] frag_pos_ff, frag_pos_in;
   logic [12:0] offset_ff, offset_in;
   logic        dropping_ff, dropping_in;
   logic        plan_valid_ff, plan_valid_in;
   plan_type    plan_ff, plan_in;

   logic        accept, first, frag, eos, eod, mf, off_lt_len, err;
   logic [15:0] len_sel, len_eff, off_bytes, rem, psize16, plen, flags;
   logic [13:0] mtu_sat, room;

   assign req_ready = !plan_valid_ff || plan_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      first   = (seg_pos_ff == '0) && !dropping_ff;
      len_sel = first ? req_word.segment_length : len_ff;
      len_in  = accept && first ? req_word.segment_length : len_ff;
      proto_in = accept && first ? req_word.upper_protocol : proto_ff;
      df_in   = accept && first ? req_word.dont_fragment : df_ff;

      mtu_sat = (cfg.mtu < MTU_MIN) ? MTU_MIN : ((cfg.mtu > MTU_MAX) ? MTU_MAX : cfg.mtu);
      room    = mtu_sat - 14'd20;
      psize16 = {2'b00, room[13:3], 3'b000};
      len_eff = (len_sel == '0) ? 16'd1 : len_sel;
      frag    = len_eff > {2'b00, room};
      eos     = req_word.last_byte || (({1'b0, seg_pos_ff} + 17'd1) >= {1'b0, len_eff});
      err     = (seg_pos_ff == '0) && frag && df_in;

      off_bytes  = {offset_ff, 3'b000};
      off_lt_len = len_eff > off_bytes;
      rem        = len_eff - off_bytes;
      mf         = off_lt_len && (psize16 < rem);
      if (frag) begin
         plen  = off_lt_len ? ((rem < psize16) ? rem : psize16) : 16'd1;
         flags = mf ? FLAG_MF : 16'h0000;
      end else begin
         plen  = len_eff;
         flags = df_in ? FLAG_DF : 16'h0000;
      end
      eod = eos || (({2'b00, frag_pos_ff} + 16'd1) >= plen);
   end

   // next segment state and plan
   always_comb begin
      seg_pos_in    = seg_pos_ff;
      frag_pos_in   = frag_pos_ff;
      offset_in     = offset_ff;
      dropping_in   = dropping_ff;
      plan_valid_in = plan_valid_ff && !plan_ready;
      plan_in       = plan_ff;
      if (accept) begin
         plan_valid_in = 1'b0;
         if (dropping_ff) begin
            if (eos) begin
               seg_pos_in  = '0;
               dropping_in = 1'b0;
            end else begin
               seg_pos_in  = seg_pos_ff + 16'd1;
            end
         end else if (err) begin
            plan_valid_in      = 1'b1;
            plan_in            = '0;
            plan_in.eos        = 1'b1;
            plan_in.status     = 1'b1;
            if (eos) begin
               seg_pos_in  = '0;
               frag_pos_in = '0;
               offset_in   = '0;
            end else begin
               dropping_in = 1'b1;
               seg_pos_in  = 16'd1;
            end
         end else begin
            plan_valid_in        = 1'b1;
            plan_in.has_header   = (frag_pos_ff == '0);
            plan_in.total_length = plen + HDR_LEN16;
            plan_in.flags_offset = flags | {3'b000, offset_ff};
            plan_in.protocol     = proto_in;
            plan_in.data_byte    = req_word.payload_byte;
            plan_in.eod          = eod;
            plan_in.eos          = eos;
            plan_in.status       = 1'b0;
            if (eos) begin
               seg_pos_in  = '0;
               frag_pos_in = '0;
               offset_in   = '0;
               dropping_in = 1'b0;
            end else begin
               seg_pos_in = seg_pos_ff + 16'd1;
               if (eod) begin
                  offset_in   = offset_ff + 13'((15'(frag_pos_ff) + 15'd1) >> 3);
                  frag_pos_in = '0;
               end else begin
                  frag_pos_in = frag_pos_ff + 14'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         proto_ff      <= '0;
         df_ff         <= 1'b0;
         seg_pos_ff    <= '0;
         frag_pos_ff   <= '0;
         offset_ff     <= '0;
         dropping_ff   <= 1'b0;
         plan_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         proto_ff      <= proto_in;
         df_ff         <= df_in;
         seg_pos_ff    <= seg_pos_in;
         frag_pos_ff   <= frag_pos_in;
         offset_ff     <= offset_in;
         dropping_ff   <= dropping_in;
         plan_valid_ff <= plan_valid_in;
      end
      plan_ff <= plan_in;
   end

   assign plan_valid = plan_valid_ff;
   assign plan       = plan_ff;

endmodule

`default_nettype wire

FILE: rtl/ihbf_hdr_emit.sv
// Header serializer: holds one plan, computes the header checksum and
// sends header bytes and the payload byte through the output register.
// Depends on ihbf_pkg.
`default_nettype none

module ihbf_hdr_emit (
   input  wire                     clock,
   input  wire                     reset,
   input  ihbf_pkg::cfg_type       cfg,
   input  wire                     plan_valid,
   output logic                    plan_ready,
   input  ihbf_pkg::plan_type      plan,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output ihbf_pkg::rsp_word_type  rsp_word
);
   import ihbf_pkg::*;

   plan_type         buf_ff;
   logic             buf_valid_ff, buf_valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      csum_ff, csum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   logic         out_free, move, last_move, load;
   logic [19:0]  sum;
   logic [16:0]  fold1;
   logic [16:0]  fold2;
   logic [7:0]   hdr_byte;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign move       = buf_valid_ff && out_free;
   assign last_move  = move && (idx_ff == PAYLOAD_INDEX);
   assign plan_ready = !buf_valid_ff || last_move;
   assign load       = plan_valid && plan_ready;

   // checksum is registered from the held plan (buf_ff, then csum_ff), well before its byte goes out
   always_comb begin
      sum = 20'({VERSION_IHL, 8'h00}) + 20'(buf_ff.total_length)
          + 20'(cfg.identification) + 20'(buf_ff.flags_offset)
          + 20'({TTL_VALUE, buf_ff.protocol})
          + 20'(cfg.source_address[31:16]) + 20'(cfg.source_address[15:0])
          + 20'(cfg.destination_address[31:16])
          + 20'(cfg.destination_address[15:0]);
      fold1   = 17'(sum[15:0]) + 17'(sum[19:16]);
      fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
      csum_in = ~fold2[15:0];
   end

   always_comb begin
      case (idx_ff)
         5'd0:    hdr_byte = VERSION_IHL;
         5'd1:    hdr_byte = 8'h00;
         5'd2:    hdr_byte = buf_ff.total_length[15:8];
         5'd3:    hdr_byte = buf_ff.total_length[7:0];
         5'd4:    hdr_byte = cfg.identification[15:8];
         5'd5:    hdr_byte = cfg.identification[7:0];
         5'd6:    hdr_byte = buf_ff.flags_offset[15:8];
         5'd7:    hdr_byte = buf_ff.flags_offset[7:0];
         5'd8:    hdr_byte = TTL_VALUE;
         5'd9:    hdr_byte = buf_ff.protocol;
         5'd10:   hdr_byte = csum_ff[15:8];
         5'd11:   hdr_byte = csum_ff[7:0];
         5'd12:   hdr_byte = cfg.source_address[31:24];
         5'd13:   hdr_byte = cfg.source_address[23:16];
         5'd14:   hdr_byte = cfg.source_address[15:8];
         5'd15:   hdr_byte = cfg.source_address[7:0];
         5'd16:   hdr_byte = cfg.destination_address[31:24];
         5'd17:   hdr_byte = cfg.destination_address[23:16];
         5'd18:   hdr_byte = cfg.destination_address[15:8];
         5'd19:   hdr_byte = cfg.destination_address[7:0];
         default: hdr_byte = buf_ff.data_byte;
      endcase
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         buf_valid_in = 1'b1;
         idx_in       = plan.has_header ? '0 : PAYLOAD_INDEX;
      end else if (last_move) begin
         buf_valid_in = 1'b0;
      end else if (move) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (move) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_byte     = hdr_byte;
         if (idx_ff == PAYLOAD_INDEX) begin
            rsp_in.end_of_datagram = buf_ff.eod;
            rsp_in.end_of_segment  = buf_ff.eos;
            rsp_in.status          = buf_ff.status;
         end else begin
            rsp_in.end_of_datagram = 1'b0;
            rsp_in.end_of_segment  = 1'b0;
            rsp_in.status          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         buf_ff <= plan;
      end
      csum_ff <= csum_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/ipv4_header_build_and_fragment_unit.sv
// IPv4 header build and fragment unit, top level.
// Path: an accepted word passes the plan register, serializer buffer and output
// register. Throughput: one input word per cycle while no header is due and the
// output is not stalled; a datagram's first word also puts out 20 header bytes.
// Reset: synchronous; clears segment state and valid flags, loads register defaults.
// Depends on ihbf_pkg, ihbf_csr, ihbf_seg_ctrl and ihbf_hdr_emit.
`default_nettype none

module ipv4_header_build_and_fragment_unit (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  ihbf_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output ihbf_pkg::rsp_word_type  rsp_word,
   input  wire                     csr_write_enable,
   input  ihbf_pkg::csr_index_type csr_index,
   input  wire [31:0]              csr_write_data
);
   import ihbf_pkg::*;

   cfg_type  cfg;
   plan_type plan;
   logic     plan_valid;
   logic     plan_ready;

   ihbf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ihbf_seg_ctrl u_seg_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .plan_valid (plan_valid),
      .plan_ready (plan_ready),
      .plan       (plan)
   );

   ihbf_hdr_emit u_hdr_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .plan_valid (plan_valid),
      .plan_ready (plan_ready),
      .plan       (plan),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
